// ===== sv/nrsp_pkg.sv =====
`default_nettype none

package nrsp_pkg;

    // fixed widths of the payload and configuration fields
    localparam int COUNT_W    = 7;
    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int IDX_OUT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Q1.15 one for the jitter reach
    localparam logic [15:0] REACH_ONE = 16'd32768;

    localparam logic [COUNT_W-1:0] COUNT_RST  = 7'd16;
    localparam logic [COORD_W-1:0] WIDTH_RST  = 16'd256;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 16'd256;
    localparam logic [15:0]        REACH_RST  = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_SPACE_WIDTH  = 2'd1,
        CFG_SPACE_HEIGHT = 2'd2,
        CFG_JITTER_REACH = 2'd3
    } t_cfg_reg;

endpackage

`default_nettype wire

// ===== sv/n_rooks_sample_pattern_generator_unit.sv =====
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_rand_column, i_rand_x, i_rand_y
// out      | output    | o_out_valid / i_out_ready  | o_accepted, o_row_index, o_column_index,
//          |           |                            | o_sample_x, o_sample_y, o_last_of_pattern
// cfg      | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One beat at a time: a draw multiply, a free-column scan (later rows only), then per axis
// two multiplies, one add and a restoring divide of CW+16 quotient bits on the shared
// multiplier and divider, CW = clog2(MAX_SAMPLES). Rejected beats skip the axes.
// Reset is synchronous; the column map is cleared in the same cycle, no clearing pass.
// o_in_ready is low from acceptance until the result beat has been taken.
`default_nettype none

module n_rooks_sample_pattern_generator_unit
    import nrsp_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int RAND_BITS   = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,

    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire [RAND_BITS-1:0]   i_rand_column,
    input  wire [RAND_BITS-1:0]   i_rand_x,
    input  wire [RAND_BITS-1:0]   i_rand_y,

    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic                  o_accepted,
    output logic [IDX_OUT_W-1:0]  o_row_index,
    output logic [IDX_OUT_W-1:0]  o_column_index,
    output logic [COORD_W-1:0]    o_sample_x,
    output logic [COORD_W-1:0]    o_sample_y,
    output logic                  o_last_of_pattern
);

    localparam int CW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = CW + 32;
    localparam int BW   = 16;
    localparam int PW   = AW + BW;
    localparam int DW   = CW + 16;
    localparam int CNTW = $clog2(DW);

    typedef enum logic [3:0] {
        S_IDLE, S_DRAW, S_PICK, S_SCAN, S_JMUL, S_JADD, S_TMUL, S_DIV, S_OUT
    } t_state;

    t_state                 r_state;

    logic [COUNT_W-1:0]     r_count;
    logic [COORD_W-1:0]     r_width;
    logic [COORD_W-1:0]     r_height;
    logic [15:0]            r_reach;

    logic [MAX_SAMPLES-1:0] r_taken;
    logic [CW-1:0]          r_row;

    logic [RAND_BITS-1:0]   r_ucol;
    logic [FRAC_W-1:0]      r_ux;
    logic [FRAC_W-1:0]      r_uy;

    logic [PW-1:0]          r_prod;
    logic [AW-1:0]          r_t;
    logic [CW-1:0]          r_k;
    logic [NW-1:0]          r_scan;
    logic [CW-1:0]          r_seen;
    logic                   r_axis;

    logic [DW-1:0]          r_quo;
    logic [NW-1:0]          r_rem;
    logic [CNTW-1:0]        r_cnt;

    logic                   r_acc;
    logic [CW-1:0]          r_col;
    logic [COORD_W-1:0]     r_sx;
    logic [COORD_W-1:0]     r_sy;
    logic                   r_last;

    // effective count, saturated to [1, MAX_SAMPLES]
    logic [8:0]             sc9;
    logic [NW-1:0]          n_eff;
    logic                   early;
    logic [15:0]            reach_sat;
    logic [AW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic [PW-1:0]          n_prod;
    logic [CW-1:0]          draw_val;
    logic [CW-1:0]          draw_col;
    logic [33:0]            jit;
    logic [CW-1:0]          strata;
    logic [COORD_W-1:0]     extent;
    logic [NW:0]            div_sh;
    logic                   div_ge;
    logic [NW:0]            div_sub;
    logic [DW-1:0]          quo_fin;
    logic [COORD_W-1:0]     coord;
    logic                   in_fire;
    logic                   out_fire;
    logic [CW+IDX_OUT_W-1:0] row_ext;
    logic [CW+IDX_OUT_W-1:0] col_ext;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    always_comb begin
        sc9 = {2'b00, r_count};
        if (sc9 == 9'd0) begin
            n_eff = NW'(1);
        end else if (sc9 > 9'(MAX_SAMPLES)) begin
            n_eff = NW'(MAX_SAMPLES);
        end else begin
            n_eff = NW'(sc9);
        end
    end

    assign early     = NW'(r_row) < (n_eff >> 2);
    assign reach_sat = (r_reach > REACH_ONE) ? REACH_ONE : r_reach;
    assign strata    = r_axis ? r_col : r_row;
    assign extent    = r_axis ? r_height : r_width;

    // shared multiplier: column draw, jitter term and position times extent
    always_comb begin
        unique case (r_state)
            S_DRAW: begin
                mul_a = AW'(r_ucol);
                mul_b = early ? BW'(n_eff) : BW'(n_eff - NW'(r_row));
            end
            S_JMUL: begin
                mul_a = AW'(r_axis ? r_uy : r_ux);
                mul_b = reach_sat;
            end
            S_TMUL: begin
                mul_a = r_t;
                mul_b = extent;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = PW'(mul_a) * PW'(mul_b);

    assign draw_val = CW'(r_prod >> RAND_BITS);
    assign draw_col = (NW'(draw_val) >= n_eff) ? CW'(n_eff - NW'(1)) : draw_val;

    // 2^31 - 65536*r + 2*u*r, always within [0, 2^32)
    assign jit = (34'd1 << 31) - (34'(reach_sat) << 16) + (34'(r_prod[31:0]) << 1);

    // restoring divide by n, one quotient bit a cycle
    assign div_sh  = {r_rem, r_quo[DW-1]};
    assign div_ge  = div_sh >= {1'b0, n_eff};
    assign div_sub = div_ge ? (div_sh - {1'b0, n_eff}) : div_sh;
    assign quo_fin = {r_quo[DW-2:0], div_ge};
    assign coord   = (quo_fin > DW'(extent)) ? extent : COORD_W'(quo_fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= COUNT_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_reach  <= REACH_RST;
            r_taken  <= '0;
            r_row    <= '0;
            r_axis   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_SAMPLE_COUNT: begin
                        r_count <= i_cfg_data[COUNT_W-1:0];
                        r_taken <= '0;
                        r_row   <= '0;
                    end
                    CFG_SPACE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SPACE_HEIGHT: r_height <= i_cfg_data;
                    CFG_JITTER_REACH: r_reach  <= i_cfg_data;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_ucol <= i_rand_column;
                        r_ux   <= FRAC_W'({i_rand_x, 16'd0} >> RAND_BITS);
                        r_uy   <= FRAC_W'({i_rand_y, 16'd0} >> RAND_BITS);
                        if (NW'(r_row) >= n_eff) begin
                            r_taken <= '0;
                            r_row   <= '0;
                        end
                        r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    r_prod  <= n_prod;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    r_axis <= 1'b0;
                    r_last <= NW'(r_row) == (n_eff - NW'(1));
                    if (early) begin
                        r_col <= draw_col;
                        if (r_taken[draw_col]) begin
                            r_acc   <= 1'b0;
                            r_sx    <= '0;
                            r_sy    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_acc             <= 1'b1;
                            r_taken[draw_col] <= 1'b1;
                            r_state           <= S_JMUL;
                        end
                    end else begin
                        r_k     <= draw_val;
                        r_scan  <= '0;
                        r_seen  <= '0;
                        r_acc   <= 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan == n_eff) begin
                        // no free column: report column 0, mark nothing
                        r_col   <= '0;
                        r_state <= S_JMUL;
                    end else if (!r_taken[r_scan[CW-1:0]]) begin
                        if (r_seen == r_k) begin
                            r_col                    <= r_scan[CW-1:0];
                            r_taken[r_scan[CW-1:0]] <= 1'b1;
                            r_state                  <= S_JMUL;
                        end else begin
                            r_seen <= r_seen + CW'(1);
                            r_scan <= r_scan + NW'(1);
                        end
                    end else begin
                        r_scan <= r_scan + NW'(1);
                    end
                end
                S_JMUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_JADD;
                end
                S_JADD: begin
                    r_t     <= {strata, jit[31:0]};
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    // floor(P / (n*2^32)) == floor((P >> 32) / n)
                    r_quo   <= n_prod[PW-1:32];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= quo_fin;
                    r_rem <= NW'(div_sub);
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(DW - 1)) begin
                        if (r_axis) begin
                            r_sy    <= coord;
                            r_state <= S_OUT;
                        end else begin
                            r_sx    <= coord;
                            r_axis  <= 1'b1;
                            r_state <= S_JMUL;
                        end
                    end
                end
                S_OUT: begin
                    if (out_fire) begin
                        if (r_acc) begin
                            if (r_last) begin
                                r_taken <= '0;
                                r_row   <= '0;
                            end else begin
                                r_row <= r_row + CW'(1);
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign row_ext = {{IDX_OUT_W{1'b0}}, r_row};
    assign col_ext = {{IDX_OUT_W{1'b0}}, r_col};

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = (r_state == S_OUT);
    assign o_accepted        = r_acc;
    assign o_row_index       = row_ext[IDX_OUT_W-1:0];
    assign o_column_index    = col_ext[IDX_OUT_W-1:0];
    assign o_sample_x        = r_sx;
    assign o_sample_y        = r_sy;
    assign o_last_of_pattern = r_acc && r_last;

`ifndef NO_ASSERTIONS
    // one column marked per placed row
    a_map_matches_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_taken) == int'(r_row)))
        else $error("column map count differs from current row");

    a_ready_excl_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |->
            (o_sample_x == '0 && o_sample_y == '0 && !o_last_of_pattern))
        else $error("rejected beat carries a position");

    a_clamp_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_sample_x <= r_width && o_sample_y <= r_height))
        else $error("sample outside the area");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("ready again straight after accepting a beat");
`endif

endmodule

`default_nettype wire
